### src/pcx_pkg.sv
// shared types and constants for the pcx run-length scan-line decoder
// used by every design module of the block; depends on nothing
package pcx_pkg;

    localparam logic [7:0] RUN_MARK = 8'hC0;
    localparam logic [5:0] RUN_MASK = 6'h3F;
    localparam logic [3:0] MAX_PLANES = 4'd8;

    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_PLANAR_MODE    = 3'd0,
        REG_BYTES_PER_LINE = 3'd1,
        REG_PLANE_COUNT    = 3'd2,
        REG_IMAGE_WIDTH    = 3'd3,
        REG_IMAGE_HEIGHT   = 3'd4
    } pcx_reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } pcx_state_t;

    typedef struct packed {
        logic        planar_mode;
        logic [15:0] bytes_per_line;
        logic [3:0]  plane_count;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } pcx_cfg_t;

    typedef struct packed {
        logic take;
        logic emit;
    } pcx_cmd_t;

    typedef struct packed {
        logic start_run;
        logic last_write;
    } pcx_stat_t;

endpackage

### src/pcx_rle_scanline_decoder.sv
// top level of the pcx run-length scan-line decoder
// depends on pcx_pkg, pcx_cfg, pcx_ctrl and pcx_dp
//
// Decodes a PCX run-length byte stream into image-buffer writes, one write per
// result transaction. A literal byte is accepted in the idle state and loads the
// output register in the emit state. A repeat prefix is accepted and produces
// nothing; the byte after it is accepted and then expands into up to 63 writes,
// one per cycle while pixel_ready allows, driven by the run counter of the
// datapath. While a run expands, coded_ready is low. The output register lets the
// next byte be taken while the last write still waits for pixel_ready. Registers
// must be set over the APB port while the block is idle; the block does not
// enforce it. After the final row all further bytes are dropped until reset.
module pcx_rle_scanline_decoder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pcx_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       coded_valid,
    output logic                       coded_ready,
    input  logic [7:0]                 coded_byte,
    output logic                       pixel_valid,
    input  logic                       pixel_ready,
    output logic [31:0]                pixel_address,
    output logic [7:0]                 pixel_data,
    output logic                       write_or,
    output logic [2:0]                 plane_index,
    output logic                       last_of_run,
    output logic                       image_done
);

    pcx_pkg::pcx_cfg_t  cfg;
    pcx_pkg::pcx_cmd_t  cmd;
    pcx_pkg::pcx_stat_t stat;

    assign pready = 1'b1;

    pcx_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    pcx_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .coded_valid (coded_valid),
        .coded_ready (coded_ready),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    pcx_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .stat          (stat),
        .coded_byte    (coded_byte),
        .pixel_address (pixel_address),
        .pixel_data    (pixel_data),
        .write_or      (write_or),
        .plane_index   (plane_index),
        .last_of_run   (last_of_run),
        .image_done    (image_done)
    );

endmodule

### src/pcx_cfg.sv
// apb configuration registers of the pcx decoder
// depends on pcx_pkg
module pcx_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pcx_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output pcx_pkg::pcx_cfg_t          cfg
);

    pcx_pkg::pcx_cfg_t cfg_reg;
    pcx_pkg::pcx_reg_idx_t idx;
    logic wr_en;

    assign idx   = pcx_pkg::pcx_reg_idx_t'(paddr[pcx_pkg::ADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.planar_mode    <= 1'b0;
            cfg_reg.bytes_per_line <= 16'd1;
            cfg_reg.plane_count    <= 4'd1;
            cfg_reg.image_width    <= 16'd1;
            cfg_reg.image_height   <= 16'd1;
        end
        else if (wr_en)
        begin
            unique case (idx)
                pcx_pkg::REG_PLANAR_MODE:    cfg_reg.planar_mode    <= pwdata[0];
                pcx_pkg::REG_BYTES_PER_LINE: cfg_reg.bytes_per_line <= pwdata[15:0];
                pcx_pkg::REG_PLANE_COUNT:    cfg_reg.plane_count    <= pwdata[3:0];
                pcx_pkg::REG_IMAGE_WIDTH:    cfg_reg.image_width    <= pwdata[15:0];
                pcx_pkg::REG_IMAGE_HEIGHT:   cfg_reg.image_height   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            pcx_pkg::REG_PLANAR_MODE:    prdata = {31'd0, cfg_reg.planar_mode};
            pcx_pkg::REG_BYTES_PER_LINE: prdata = {16'd0, cfg_reg.bytes_per_line};
            pcx_pkg::REG_PLANE_COUNT:    prdata = {28'd0, cfg_reg.plane_count};
            pcx_pkg::REG_IMAGE_WIDTH:    prdata = {16'd0, cfg_reg.image_width};
            pcx_pkg::REG_IMAGE_HEIGHT:   prdata = {16'd0, cfg_reg.image_height};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

### src/pcx_ctrl.sv
// controller of the pcx decoder: byte intake, run expansion and output handshake
// depends on pcx_pkg
module pcx_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               coded_valid,
    output logic               coded_ready,
    output logic               pixel_valid,
    input  logic               pixel_ready,
    input  pcx_pkg::pcx_stat_t stat,
    output pcx_pkg::pcx_cmd_t  cmd
);

    pcx_pkg::pcx_state_t state_reg, state_next;
    logic valid_reg, valid_next;
    logic out_free;

    assign out_free    = !valid_reg || pixel_ready;
    assign coded_ready = (state_reg == pcx_pkg::ST_IDLE);
    assign pixel_valid = valid_reg;

    always_comb
    begin
        cmd.take   = 1'b0;
        cmd.emit   = 1'b0;
        state_next = state_reg;
        valid_next = valid_reg && !pixel_ready;
        unique case (state_reg)
            pcx_pkg::ST_IDLE:
            begin
                if (coded_valid)
                begin
                    cmd.take = 1'b1;
                    if (stat.start_run)
                        state_next = pcx_pkg::ST_EMIT;
                end
            end
            pcx_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    valid_next = 1'b1;
                    if (stat.last_write)
                        state_next = pcx_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcx_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcx_pkg::ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

### src/pcx_dp.sv
// datapath of the pcx decoder: run state, cursor, line and row tracking, output register
// depends on pcx_pkg
module pcx_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  pcx_pkg::pcx_cfg_t  cfg,
    input  pcx_pkg::pcx_cmd_t  cmd,
    output pcx_pkg::pcx_stat_t stat,
    input  logic [7:0]         coded_byte,
    output logic [31:0]        pixel_address,
    output logic [7:0]         pixel_data,
    output logic               write_or,
    output logic [2:0]         plane_index,
    output logic               last_of_run,
    output logic               image_done
);

    logic [5:0]  pending_reg, pending_next;
    logic        armed_reg, armed_next;
    logic [5:0]  rem_reg, rem_next;
    logic [7:0]  byte_reg, byte_next;
    logic [15:0] lbc_reg, lbc_next;
    logic [2:0]  plane_reg, plane_next;
    logic [15:0] row_reg, row_next;
    logic [31:0] ls_reg, ls_next;
    logic [31:0] cursor_reg, cursor_next;
    logic        finished_reg, finished_next;

    logic        is_prefix;
    logic [31:0] cur_inc, ls_inc;
    logic [15:0] lbc_inc;
    logic [16:0] row_inc;
    logic [3:0]  planes_used, plane_inc;
    logic        line_end, plane_last, row_last, done_now;

    assign is_prefix = (coded_byte & pcx_pkg::RUN_MARK) == pcx_pkg::RUN_MARK;

    assign cur_inc   = cursor_reg + (cfg.planar_mode ? 32'd8 : 32'd1);
    assign lbc_inc   = lbc_reg + 16'd1;
    assign ls_inc    = ls_reg + {16'd0, cfg.image_width};
    assign row_inc   = {1'b0, row_reg} + 17'd1;
    assign plane_inc = {1'b0, plane_reg} + 4'd1;

    always_comb
    begin
        priority if (cfg.plane_count == 4'd0)
            planes_used = 4'd1;
        else if (cfg.plane_count > pcx_pkg::MAX_PLANES)
            planes_used = pcx_pkg::MAX_PLANES;
        else
            planes_used = cfg.plane_count;
    end

    assign line_end   = (lbc_inc == cfg.bytes_per_line);
    assign plane_last = (plane_inc >= planes_used);
    assign row_last   = (row_inc >= {1'b0, cfg.image_height});
    assign done_now   = line_end && plane_last && row_last;

    assign stat.start_run  = !finished_reg &&
                             (armed_reg ? (pending_reg != 6'd0) : !is_prefix);
    assign stat.last_write = (rem_reg == 6'd1) || done_now;

    always_comb
    begin
        pending_next  = pending_reg;
        armed_next    = armed_reg;
        rem_next      = rem_reg;
        byte_next     = byte_reg;
        lbc_next      = lbc_reg;
        plane_next    = plane_reg;
        row_next      = row_reg;
        ls_next       = ls_reg;
        cursor_next   = cursor_reg;
        finished_next = finished_reg;
        if (cmd.take && !finished_reg)
        begin
            byte_next = coded_byte;
            priority if (armed_reg)
            begin
                armed_next   = 1'b0;
                pending_next = 6'd0;
                rem_next     = pending_reg;
            end
            else if (is_prefix)
            begin
                armed_next   = 1'b1;
                pending_next = coded_byte[5:0] & pcx_pkg::RUN_MASK;
            end
            else
            begin
                rem_next = 6'd1;
            end
        end
        if (cmd.emit)
        begin
            rem_next = rem_reg - 6'd1;
            if (line_end)
            begin
                lbc_next = 16'd0;
                if (plane_last)
                begin
                    plane_next    = 3'd0;
                    ls_next       = ls_inc;
                    cursor_next   = ls_inc;
                    row_next      = row_inc[15:0];
                    finished_next = row_last;
                end
                else
                begin
                    plane_next  = plane_inc[2:0];
                    cursor_next = ls_reg;
                end
            end
            else
            begin
                lbc_next    = lbc_inc;
                cursor_next = cur_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= 6'd0;
            armed_reg    <= 1'b0;
            rem_reg      <= 6'd0;
            lbc_reg      <= 16'd0;
            plane_reg    <= 3'd0;
            row_reg      <= 16'd0;
            ls_reg       <= 32'd0;
            cursor_reg   <= 32'd0;
            finished_reg <= 1'b0;
        end
        else
        begin
            pending_reg  <= pending_next;
            armed_reg    <= armed_next;
            rem_reg      <= rem_next;
            lbc_reg      <= lbc_next;
            plane_reg    <= plane_next;
            row_reg      <= row_next;
            ls_reg       <= ls_next;
            cursor_reg   <= cursor_next;
            finished_reg <= finished_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        if (cmd.emit)
        begin
            pixel_address <= cursor_reg;
            pixel_data    <= byte_reg;
            write_or      <= cfg.planar_mode;
            plane_index   <= cfg.planar_mode ? plane_reg : 3'd0;
            last_of_run   <= (rem_reg == 6'd1) || done_now;
            image_done    <= done_now;
        end
    end

endmodule

### src/pcx_checker.sv
// port-level checks for the pcx decoder, bound to the top level
// depends on pcx_rle_scanline_decoder
module pcx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pixel_valid,
    input logic        pixel_ready,
    input logic [31:0] pixel_address,
    input logic        write_or,
    input logic [2:0]  plane_index,
    input logic        last_of_run,
    input logic        image_done
);

    // a stalled write holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel_address))
        else $error("stalled write changed");

    // the final write also closes its run
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && image_done |-> last_of_run)
        else $error("image_done without last_of_run");

    // nothing follows the final write
    a_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready && image_done |=> !pixel_valid)
        else $error("write after image done");

    // byte stores carry plane zero
    a_byte_plane: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !write_or |-> plane_index == 3'd0)
        else $error("plane index set on byte store");

endmodule

bind pcx_rle_scanline_decoder pcx_checker u_pcx_checker (.*);
